/* hdl/ep0_pkg.sv */
// ----------------------------------------------------------------------------
// Endpoint 0 request engine package
// Shared constants, request codes and the descriptor ROM contents.
// ----------------------------------------------------------------------------
package ep0_pkg;

  localparam int unsigned MaxPacket = 64;
  localparam int unsigned RomDepth  = 256;
  localparam int unsigned RomAw     = $clog2(RomDepth);

  // Event kinds.
  localparam logic [1:0] EvSetup = 2'd0;
  localparam logic [1:0] EvIn    = 2'd1;
  localparam logic [1:0] EvOut   = 2'd2;
  localparam logic [1:0] EvReset = 2'd3;

  // Endpoint responses.
  localparam logic [1:0] RespAck   = 2'd0;
  localparam logic [1:0] RespNak   = 2'd1;
  localparam logic [1:0] RespStall = 2'd2;

  // Request codes.
  localparam logic [7:0] ReqGetStatus  = 8'h00;
  localparam logic [7:0] ReqClrFeature = 8'h01;
  localparam logic [7:0] ReqSetAddress = 8'h05;
  localparam logic [7:0] ReqGetDesc    = 8'h06;
  localparam logic [7:0] ReqGetConfig  = 8'h08;
  localparam logic [7:0] ReqSetConfig  = 8'h09;
  localparam logic [7:0] ReqSetIdle    = 8'h0a;

  // Configuration register indexes.
  localparam logic CfgVendor  = 1'b0;
  localparam logic CfgProduct = 1'b1;

  // Descriptor ROM contents; bytes 7 to 11 are overlaid at read time.
  function automatic logic [7:0] rom_byte(input logic [RomAw-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    unique case (a)
      8'd0: b = 8'h12; 8'd1: b = 8'h01; 8'd2: b = 8'h10; 8'd3: b = 8'h01;
      8'd17: b = 8'h01;
      8'd18: b = 8'h09; 8'd19: b = 8'h02; 8'd20: b = 8'h22; 8'd22: b = 8'h01;
      8'd23: b = 8'h01; 8'd25: b = 8'hA0; 8'd26: b = 8'h32;
      8'd27: b = 8'h09; 8'd28: b = 8'h04; 8'd31: b = 8'h01; 8'd32: b = 8'h03;
      8'd33: b = 8'h01; 8'd34: b = 8'h02;
      8'd36: b = 8'h09; 8'd37: b = 8'h21; 8'd38: b = 8'h10; 8'd39: b = 8'h01;
      8'd41: b = 8'h01; 8'd42: b = 8'h22; 8'd43: b = 8'h34;
      8'd45: b = 8'h07; 8'd46: b = 8'h05; 8'd47: b = 8'h81; 8'd48: b = 8'h03;
      8'd49: b = 8'h04; 8'd51: b = 8'h0a;
      8'd52: b = 8'h05; 8'd53: b = 8'h01; 8'd54: b = 8'h09; 8'd55: b = 8'h02;
      8'd56: b = 8'hA1; 8'd57: b = 8'h01; 8'd58: b = 8'h09; 8'd59: b = 8'h01;
      8'd60: b = 8'hA1; 8'd61: b = 8'h00; 8'd62: b = 8'h05; 8'd63: b = 8'h09;
      8'd64: b = 8'h19; 8'd65: b = 8'h01; 8'd66: b = 8'h29; 8'd67: b = 8'h03;
      8'd68: b = 8'h15; 8'd69: b = 8'h00; 8'd70: b = 8'h25; 8'd71: b = 8'h01;
      8'd72: b = 8'h75; 8'd73: b = 8'h01; 8'd74: b = 8'h95; 8'd75: b = 8'h03;
      8'd76: b = 8'h81; 8'd77: b = 8'h02; 8'd78: b = 8'h75; 8'd79: b = 8'h05;
      8'd80: b = 8'h95; 8'd81: b = 8'h01; 8'd82: b = 8'h81; 8'd83: b = 8'h01;
      8'd84: b = 8'h05; 8'd85: b = 8'h01; 8'd86: b = 8'h09; 8'd87: b = 8'h30;
      8'd88: b = 8'h09; 8'd89: b = 8'h31; 8'd90: b = 8'h09; 8'd91: b = 8'h38;
      8'd92: b = 8'h15; 8'd93: b = 8'h81; 8'd94: b = 8'h25; 8'd95: b = 8'h7f;
      8'd96: b = 8'h75; 8'd97: b = 8'h08; 8'd98: b = 8'h95; 8'd99: b = 8'h03;
      8'd100: b = 8'h81; 8'd101: b = 8'h06; 8'd102: b = 8'hC0; 8'd103: b = 8'hC0;
      8'd104: b = 8'h04; 8'd105: b = 8'h03; 8'd106: b = 8'h09; 8'd107: b = 8'h04;
      8'd108: b = 8'd16; 8'd109: b = 8'd3;
      8'd110: b = "G"; 8'd112: b = "e"; 8'd114: b = "n"; 8'd116: b = "e";
      8'd118: b = "r"; 8'd120: b = "i"; 8'd122: b = "c";
      8'd124: b = 8'd42; 8'd125: b = 8'd3;
      8'd126: b = "G"; 8'd128: b = "e"; 8'd130: b = "n"; 8'd132: b = "e";
      8'd134: b = "r"; 8'd136: b = "i"; 8'd138: b = "c"; 8'd140: b = " ";
      8'd142: b = "U"; 8'd144: b = "S"; 8'd146: b = "B"; 8'd148: b = "2";
      8'd150: b = "."; 8'd152: b = "0"; 8'd154: b = " ";
      8'd156: b = "M"; 8'd158: b = "o"; 8'd160: b = "u"; 8'd162: b = "s";
      8'd164: b = "e";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/ep0_ram.sv */
// ----------------------------------------------------------------------------
// Endpoint 0 generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ep0_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/usb_ep0_standard_request_engine_unit.sv */
// ----------------------------------------------------------------------------
// USB endpoint 0 standard request engine
// Decodes endpoint 0 events and streams descriptor bytes from a ROM held in
// a synchronous memory, one byte per result item.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_axis   | in        | tuser: req_type; tdata: bm_request_type, b_request,
//           |           |        w_value, w_index, w_length
//  m_axis   | out       | tdata: ep_response, tx_len, data_byte, byte_index,
//           |           |        data_toggle, dev_address, configuration,
//           |           |        host_ready; tlast: last
//  cfg      | in        | vendor_id (index 0), product_id (index 1)
//
// After reset a sweep of all 256 addresses loads the descriptor ROM image
// into the RAM; no item is accepted during it. An item is decoded in StIdle,
// then gives up to 64 results, one per cycle unless the output stalls, one
// RAM read ahead of each; a stall holds the output register and sequencer.
module usb_ep0_standard_request_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // bm_request_type[7:0], b_request[15:8], w_value[31:16],
  // w_index[47:32], w_length[63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ep_response[1:0], tx_len[8:2], data_byte[16:9], byte_index[22:17],
  // data_toggle[23], dev_address[30:24], configuration[38:31],
  // host_ready[39]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import ep0_pkg::*;

  localparam logic [1:0] StInit = 2'd0;
  localparam logic [1:0] StIdle = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [7:0]  init_q, init_d;
  logic [15:0] vid_q, pid_q;
  logic [6:0]  addr_q, addr_d;
  logic [7:0]  pcode_q, pcode_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  rofs_q, rofs_d;
  logic [7:0]  cfgv_q, cfgv_d;
  logic        rdy_q, rdy_d, tog_q, tog_d;
  // per item emission
  logic [1:0]  resp_q, resp_d;
  logic [6:0]  n_q, n_d;
  logic [5:0]  idx_q, idx_d;
  logic [7:0]  base_q, base_d;
  logic        rom_q, rom_d;
  logic [7:0]  inl_q, inl_d;
  logic        ovalid_q, ovalid_d;
  logic [39:0] odata_q, odata_d;
  logic        olast_q, olast_d;
  logic [7:0]  raddr;
  logic [7:0]  rdata;
  logic [8:0]  ra_q;

  // input fields
  logic [1:0]  kind;
  logic [7:0]  bm, code;
  logic [15:0] wv, wi, wl;
  assign kind = s_axis_tuser;
  assign bm   = s_axis_tdata[7:0];
  assign code = s_axis_tdata[15:8];
  assign wv   = s_axis_tdata[31:16];
  assign wi   = s_axis_tdata[47:32];
  assign wl   = s_axis_tdata[63:48];

  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  // Descriptor RAM: loaded from the ROM image after reset.
  ep0_ram #(.Width(8), .Depth(RomDepth)) u_rom (
    .clk_i   (clk_i),
    .we_i    (state_q == StInit),
    .waddr_i (init_q),
    .wdata_i (rom_byte(init_q)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  function automatic logic [6:0] pkt(input logic [15:0] r);
    return (r < 16'(MaxPacket)) ? r[6:0] : 7'(MaxPacket);
  endfunction

  logic s_acc, emit;
  logic [7:0] byte_v;
  logic [8:0] rd_addr;
  logic [15:0] dlen;
  logic [7:0]  start;
  logic        stall;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  // one output slot is taken each send cycle, when the slot is free
  assign emit = (state_q == StSend) && (!ovalid_q || m_axis_tready);

  // Byte value for the current index, with the register overlays.
  // Positions past the end of the ROM read as zero.
  always_comb begin
    unique case (ra_q)
      9'd7:  byte_v = 8'(MaxPacket);
      9'd8:  byte_v = vid_q[7:0];
      9'd9:  byte_v = vid_q[15:8];
      9'd10: byte_v = pid_q[7:0];
      9'd11: byte_v = pid_q[15:8];
      default: byte_v = ra_q[8] ? 8'h00 : rdata;
    endcase
    if (n_q == 7'd0) byte_v = 8'h00;
    else if (!rom_q) byte_v = (idx_q == 6'd0) ? inl_q : 8'h00;
  end

  // Next RAM address: stays on the current byte until it is emitted.
  always_comb begin
    rd_addr = {1'b0, base_d} + {3'b000, idx_d};
    raddr   = rd_addr[7:0];
  end

  always_comb begin
    state_d = state_q; init_d = init_q;
    addr_d = addr_q; pcode_d = pcode_q; rem_d = rem_q; rofs_d = rofs_q;
    cfgv_d = cfgv_q; rdy_d = rdy_q; tog_d = tog_q;
    resp_d = resp_q; n_d = n_q; idx_d = idx_q; base_d = base_q;
    rom_d = rom_q; inl_d = inl_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d = odata_q; olast_d = olast_q;
    dlen = 16'd0; start = 8'd0; stall = 1'b0;

    unique case (state_q)
      StInit: begin
        init_d = init_q + 8'd1;
        if (init_q == 8'(RomDepth - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (s_acc) begin
          n_d = 7'd0; idx_d = 6'd0; base_d = 8'd0; rom_d = 1'b0;
          inl_d = 8'd0; resp_d = RespNak;
          priority case (kind)
            EvOut: ;
            EvReset: begin
              addr_d = 7'd0; tog_d = 1'b0; state_d = StSend;
            end
            EvIn: begin
              state_d = StSend;
              if (pcode_q == ReqGetDesc) begin
                n_d = pkt(rem_q); base_d = rofs_q; rom_d = 1'b1;
                rem_d = rem_q - 16'(pkt(rem_q));
                rofs_d = rofs_q + 8'(pkt(rem_q));
                tog_d = !tog_q; resp_d = RespAck;
              end else begin
                if (pcode_q == ReqSetAddress) addr_d = rem_q[6:0];
                tog_d = 1'b0;
              end
            end
            default: begin
              state_d = StSend;
              pcode_d = code; rem_d = wl; tog_d = 1'b1;
              if ((bm & 8'h60) != 8'h00) begin
                if (code != ReqSetIdle && code != ReqSetConfig) stall = 1'b1;
              end else begin
                unique case (code)
                  ReqGetDesc: begin
                    unique case (wv[15:8])
                      8'h01: begin start = 8'd0; dlen = 16'd18; end
                      8'h02: begin start = 8'd18; dlen = 16'd34; end
                      8'h22: begin
                        if (wi[7:0] <= 8'd1) begin
                          start = 8'd52; dlen = 16'd52;
                          if (wi[7:0] == 8'd1) rdy_d = 1'b1;
                        end else stall = 1'b1;
                      end
                      8'h03: begin
                        unique case (wv[7:0])
                          8'd0: begin start = 8'd104; dlen = 16'd4; end
                          8'd1: begin start = 8'd108; dlen = 16'd16; end
                          8'd2: begin start = 8'd124; dlen = 16'd42; end
                          default: stall = 1'b1;
                        endcase
                      end
                      default: stall = 1'b1;
                    endcase
                    if (stall) rem_d = 16'd0;
                    else begin
                      if (wl > dlen) rem_d = dlen;
                      base_d = start; rom_d = 1'b1;
                      rofs_d = start + 8'(pkt(rem_d));
                    end
                  end
                  ReqSetAddress: rem_d = {8'd0, wv[7:0]};
                  ReqGetConfig: begin
                    inl_d = cfgv_q;
                    if (wl > 16'd1) rem_d = 16'd1;
                  end
                  ReqSetConfig: cfgv_d = wv[7:0];
                  ReqClrFeature: begin
                    if (bm[4:0] != 5'd2) stall = 1'b1;
                    else if (wi[7:0] != 8'h82 && wi[7:0] != 8'h02 &&
                             wi[7:0] != 8'h81 && wi[7:0] != 8'h01) stall = 1'b1;
                  end
                  ReqSetIdle: if (wl > 16'd1) rem_d = 16'd1;
                  ReqGetStatus: if (wl > 16'd2) rem_d = 16'd2;
                  default: stall = 1'b1;
                endcase
              end
              if (stall) resp_d = RespStall;
              else begin
                if (bm[7]) begin
                  n_d = pkt(rem_d);
                  rem_d = rem_d - 16'(pkt(rem_d));
                end
                resp_d = RespAck;
              end
            end
          endcase
        end
      end
      StSend: begin
        if (emit) begin
          ovalid_d = 1'b1;
          olast_d  = (n_q == 7'd0) || (7'(idx_q) + 7'd1 == n_q);
          odata_d  = {rdy_q, cfgv_q, addr_q, tog_q, idx_q, byte_v, n_q, resp_q};
          if (olast_d) state_d = StIdle;
          else idx_d = idx_q + 6'd1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Payload and read address registers.
  always_ff @(posedge clk_i) begin
    resp_q <= resp_d; n_q <= n_d; idx_q <= idx_d; base_q <= base_d;
    rom_q <= rom_d; inl_q <= inl_d; odata_q <= odata_d; olast_q <= olast_d;
    ra_q <= rd_addr;
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit; init_q <= 8'd0;
      vid_q <= 16'd16701; pid_q <= 16'd8455;
      addr_q <= 7'd0; pcode_q <= 8'd0; rem_q <= 16'd0; rofs_q <= 8'd0;
      cfgv_q <= 8'd0; rdy_q <= 1'b0; tog_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; init_q <= init_d;
      addr_q <= addr_d; pcode_q <= pcode_d; rem_q <= rem_d; rofs_q <= rofs_d;
      cfgv_q <= cfgv_d; rdy_q <= rdy_d; tog_q <= tog_d; ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgVendor) vid_q <= cfg_wdata_i;
        else if (cfg_index_i == CfgProduct) pid_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* test/tb_usb_ep0_standard_request_engine_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Endpoint 0 request engine testbench
// Sends setup, IN, OUT and bus reset events and predicts every result item
// from an in-bench model of the request decoder and descriptor sequencer.
// ----------------------------------------------------------------------------
module tb_usb_ep0_standard_request_engine_unit;
  import ep0_pkg::*;

  typedef struct packed {
    logic       host_ready;
    logic [7:0] configuration;
    logic [6:0] dev_address;
    logic       data_toggle;
    logic [5:0] byte_index;
    logic [7:0] data_byte;
    logic [6:0] tx_len;
    logic [1:0] ep_response;
    logic       last;
  } ep0_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_wdata_i;

  usb_ep0_standard_request_engine_unit DUT (.*);

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted device state.
  logic [15:0] vid_q, pid_q;
  logic [6:0]  addr_q;
  logic [7:0]  code_q, ofs_q, cfgval_q;
  logic [15:0] rem_q;
  logic        rdy_q, tog_q;

  ep0_result_t expected_q[$];
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned burst_left;

  // Descriptor ROM image with the overlaid identifier bytes.
  function automatic logic [7:0] desc_byte(input int unsigned a);
    logic [7:0] b;
    case (a)
      7:       b = 8'(MaxPacket);
      8:       b = vid_q[7:0];
      9:       b = vid_q[15:8];
      10:      b = pid_q[7:0];
      11:      b = pid_q[15:8];
      default: b = 8'h00;
    endcase
    if (a > 11 || a < 7) begin
      case (a)
        0: b = 8'h12; 1: b = 8'h01; 2: b = 8'h10; 3: b = 8'h01; 17: b = 8'h01;
        default: b = 8'h00;
      endcase
      if (a >= 18) b = rom_img(a);
    end
    return b;
  endfunction

  function automatic logic [7:0] rom_img(input int unsigned a);
    logic [7:0] img [0:165];
    img = '{8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h40, 8'h3d, 8'h41,
            8'h07, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
            8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'hA0, 8'h32,
            8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
            8'h09, 8'h21, 8'h10, 8'h01, 8'h00, 8'h01, 8'h22, 8'h34, 8'h00,
            8'h07, 8'h05, 8'h81, 8'h03, 8'h04, 8'h00, 8'h0a,
            8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00,
            8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h03, 8'h15, 8'h00, 8'h25, 8'h01,
            8'h75, 8'h01, 8'h95, 8'h03, 8'h81, 8'h02, 8'h75, 8'h05, 8'h95, 8'h01,
            8'h81, 8'h01, 8'h05, 8'h01, 8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h38,
            8'h15, 8'h81, 8'h25, 8'h7f, 8'h75, 8'h08, 8'h95, 8'h03, 8'h81, 8'h06,
            8'hC0, 8'hC0, 8'h04, 8'h03, 8'h09, 8'h04,
            8'd16, 8'd3, "G", 8'h00, "e", 8'h00, "n", 8'h00, "e", 8'h00,
            "r", 8'h00, "i", 8'h00, "c", 8'h00,
            8'd42, 8'd3, "G", 8'h00, "e", 8'h00, "n", 8'h00, "e", 8'h00,
            "r", 8'h00, "i", 8'h00, "c", 8'h00, " ", 8'h00,
            "U", 8'h00, "S", 8'h00, "B", 8'h00, "2", 8'h00, ".", 8'h00,
            "0", 8'h00, " ", 8'h00,
            "M", 8'h00, "o", 8'h00, "u", 8'h00, "s", 8'h00, "e", 8'h00};
    return (a < 166) ? img[a] : 8'h00;
  endfunction

  function automatic int unsigned pkt_len(input int unsigned r);
    return (r < MaxPacket) ? r : MaxPacket;
  endfunction

  // Works out the result items of one event and queues them.
  task automatic predict_event(input logic [65:0] ev);
    logic [1:0]  kind;
    logic [7:0]  bm, code;
    logic [15:0] wv, wi;
    int unsigned n, base, start, dlen, cnt;
    logic        from_rom, stall;
    logic [7:0]  first_b;
    logic [1:0]  resp;
    ep0_result_t r;
    kind = ev[1:0];
    bm = ev[9:2];
    code = ev[17:10];
    wv = ev[33:18];
    wi = ev[49:34];
    n = 0;
    base = 0;
    from_rom = 1'b0;
    first_b = 8'h00;
    resp = RespNak;
    stall = 1'b0;
    if (kind == EvOut) return;
    if (kind == EvReset) begin
      addr_q = '0;
      tog_q = 1'b0;
    end else if (kind == EvIn) begin
      if (code_q == ReqGetDesc) begin
        n = pkt_len(rem_q);
        base = ofs_q;
        from_rom = 1'b1;
        rem_q = rem_q - 16'(n);
        ofs_q = 8'(ofs_q + n);
        tog_q = !tog_q;
        resp = RespAck;
      end else begin
        if (code_q == ReqSetAddress) addr_q = rem_q[6:0];
        tog_q = 1'b0;
      end
    end else begin
      code_q = code;
      rem_q = ev[65:50];
      tog_q = 1'b1;
      if (bm[6:5] != 2'b00) begin
        if (code != ReqSetIdle && code != ReqSetConfig) stall = 1'b1;
      end else begin
        case (code)
          ReqGetDesc: begin
            start = 0;
            dlen = 0;
            case (wv[15:8])
              8'h01: begin start = 0; dlen = 18; end
              8'h02: begin start = 18; dlen = 34; end
              8'h22: begin
                if (wi[7:0] <= 8'd1) begin
                  start = 52;
                  dlen = 52;
                  if (wi[7:0] == 8'd1) rdy_q = 1'b1;
                end else stall = 1'b1;
              end
              8'h03: begin
                case (wv[7:0])
                  8'd0: begin start = 104; dlen = 4; end
                  8'd1: begin start = 108; dlen = 16; end
                  8'd2: begin start = 124; dlen = 42; end
                  default: stall = 1'b1;
                endcase
              end
              default: stall = 1'b1;
            endcase
            if (stall) rem_q = '0;
            else begin
              if (rem_q > dlen) rem_q = 16'(dlen);
              base = start;
              from_rom = 1'b1;
              ofs_q = 8'(start + pkt_len(rem_q));
            end
          end
          ReqSetAddress: rem_q = {8'h00, wv[7:0]};
          ReqGetConfig: begin
            first_b = cfgval_q;
            if (rem_q > 1) rem_q = 1;
          end
          ReqSetConfig: cfgval_q = wv[7:0];
          ReqClrFeature: begin
            if (bm[4:0] == 5'd2) begin
              if (!(wi[7:0] inside {8'h82, 8'h02, 8'h81, 8'h01})) stall = 1'b1;
            end else stall = 1'b1;
          end
          ReqSetIdle: if (rem_q > 1) rem_q = 1;
          ReqGetStatus: if (rem_q > 2) rem_q = 2;
          default: stall = 1'b1;
        endcase
      end
      if (stall) resp = RespStall;
      else begin
        if (bm[7]) begin
          n = pkt_len(rem_q);
          rem_q = rem_q - 16'(n);
        end
        resp = RespAck;
      end
    end
    cnt = (n == 0) ? 1 : n;
    for (int unsigned i = 0; i < cnt; i++) begin
      r.ep_response = resp;
      r.tx_len = 7'(n);
      r.data_byte = (n == 0) ? 8'h00 :
                    from_rom ? desc_byte(base + i) : ((i == 0) ? first_b : 8'h00);
      r.byte_index = 6'(i);
      r.last = (i + 1 == cnt);
      r.data_toggle = tog_q;
      r.dev_address = addr_q;
      r.configuration = cfgval_q;
      r.host_ready = rdy_q;
      expected_q.push_back(r);
    end
  endtask

  // Sends one event in bursts with random gaps between them.
  task automatic send_event(input logic [65:0] ev);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= ev[1:0];
    s_axis_tdata <= ev[65:2];
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_event(ev);
  endtask

  function automatic logic [65:0] mk_setup(input logic [7:0] bm, input logic [7:0] code,
                                           input logic [15:0] wv, input logic [15:0] wi,
                                           input logic [15:0] wl);
    return {wl, wi, wv, code, bm, EvSetup};
  endfunction

  function automatic logic [65:0] mk_event(input logic [1:0] kind);
    return {64'($urandom) ^ {32'($urandom), 32'h0}, kind};
  endfunction

  // Waits for every outstanding result plus a short drain.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgVendor) vid_q = val;
    else pid_q = val;
  endtask

  // Fetches a whole descriptor with the IN packets that follow it.
  task automatic get_desc(input logic [15:0] wv, input logic [15:0] wi,
                          input logic [15:0] wl);
    send_event(mk_setup(8'h80, ReqGetDesc, wv, wi, wl));
    repeat (3) send_event({64'h0, EvIn});
    send_event({64'h0, EvOut});
  endtask

  task automatic test_directed();
    get_desc(16'h0100, 16'h0000, 16'hffff);
    get_desc(16'h0200, 16'h0000, 16'd9);
    get_desc(16'h2200, 16'h0001, 16'd200);
    get_desc(16'h2200, 16'h0002, 16'd52);
    get_desc(16'h0302, 16'h0000, 16'd255);
    send_event(mk_setup(8'h00, ReqSetAddress, 16'h007f, 16'h0, 16'h0));
    send_event({64'h0, EvIn});
    send_event(mk_setup(8'h00, ReqSetConfig, 16'h00ff, 16'h0, 16'h0));
    send_event(mk_setup(8'h80, ReqGetConfig, 16'h0, 16'h0, 16'hffff));
    send_event(mk_setup(8'h80, ReqGetStatus, 16'h0, 16'h0, 16'd5));
    send_event(mk_setup(8'h02, ReqClrFeature, 16'h0, 16'h0081, 16'h0));
    send_event(mk_setup(8'h00, ReqClrFeature, 16'h0, 16'h0081, 16'h0));
    send_event(mk_setup(8'h21, ReqSetIdle, 16'h0, 16'h0, 16'h0));
    send_event(mk_setup(8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff));
    send_event({64'h0, EvReset});
  endtask

  task automatic test_random(input int unsigned items);
    logic [7:0]  codes [0:7];
    logic [15:0] wv;
    codes = '{ReqGetStatus, ReqClrFeature, ReqSetAddress, ReqGetDesc,
              ReqGetConfig, ReqSetConfig, ReqSetIdle, 8'h03};
    for (int unsigned k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0: wv = 16'h0100;
          1: wv = 16'h0200;
          2: wv = {8'h03, 8'($urandom_range(0, 3))};
          3: wv = 16'h2200;
          default: wv = 16'($urandom);
        endcase
        send_event(mk_setup({1'($urandom), 2'($urandom_range(0, 3) == 0 ? $urandom : 0),
                             5'($urandom_range(0, 3))},
                            codes[$urandom_range(0, 7)], wv,
                            16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3))
                              | ({$urandom_range(0, 1)} ? 16'h0 : 16'h0080),
                            16'($urandom_range(0, 1) ? $urandom_range(0, 70) : $urandom)));
        repeat ($urandom_range(0, 2)) send_event({64'($urandom), EvIn});
      end else send_event(mk_event(2'($urandom)));
    end
  endtask

  // Stalls the result side on a repeating pattern with random stretches.
  initial begin
    int unsigned ph;
    m_axis_tready = 1'b0;
    ph = 0;
    forever begin
      @(posedge clk_i);
      ph++;
      if (ph % 200 < 60) m_axis_tready <= 1'b1;
      else m_axis_tready <= (ph % 5 != 0) && ($urandom_range(0, 3) != 0);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    ep0_result_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[39], m_axis_tdata[38:31], m_axis_tdata[30:24],
             m_axis_tdata[23], m_axis_tdata[22:17], m_axis_tdata[16:9],
             m_axis_tdata[8:2], m_axis_tdata[1:0], m_axis_tlast};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got != exp_r) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgVendor;
    cfg_wdata_i = '0;
    vid_q = 16'd16701;
    pid_q = 16'd8455;
    addr_q = '0;
    code_q = '0;
    ofs_q = '0;
    cfgval_q = '0;
    rem_q = '0;
    rdy_q = 1'b0;
    tog_q = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    write_reg(CfgVendor, 16'hffff);
    write_reg(CfgProduct, 16'h0000);
    get_desc(16'h0100, 16'h0, 16'd18);
    test_random(75);
    wait_drained();
    write_reg(CfgVendor, 16'h0000);
    write_reg(CfgProduct, 16'hffff);
    test_random(75);
    wait_drained();
    write_reg(CfgVendor, 16'($urandom));
    write_reg(CfgProduct, 16'($urandom));
    test_random(75);
    wait_drained();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
